// ===== rtl/lqs_pkg.sv =====
`default_nettype none

package lqs_pkg;

   // Field formats
   localparam int COORD_WIDTH     = 24;
   localparam int FRAC_BITS       = 8;
   localparam int STRIP_VERTICES  = 6;
   localparam int SCALE_WIDTH     = 10;
   localparam int SCALE_FRAC      = 8;
   localparam int LINE_WIDTH_BITS = 12;
   localparam int WIDTH_FRAC      = 4;
   localparam int SPREAD_SHIFT    = 3;
   localparam int COLOR_WIDTH     = 8;
   localparam int OUT_WIDTH       = 28;
   localparam int UNIT_FRAC       = 30;

   // Derived datapath widths
   localparam int SCALED_WIDTH   = COORD_WIDTH + SCALE_WIDTH + 1 - SCALE_FRAC;
   localparam int DELTA_WIDTH    = SCALED_WIDTH + 1;
   localparam int DIR_WIDTH      = UNIT_FRAC;
   localparam int EXT_WIDTH      = (DELTA_WIDTH > DIR_WIDTH) ? DELTA_WIDTH : DIR_WIDTH;
   localparam int PRE_SHIFT_WIDTH = $clog2(EXT_WIDTH + 1);
   localparam int NORM_WIDTH     = DIR_WIDTH + 1;
   localparam int SQUARE_WIDTH   = 2 * DIR_WIDTH;
   localparam int SUMSQ_WIDTH    = 2 * DIR_WIDTH + 2;
   localparam int ROOT_WIDTH     = SUMSQ_WIDTH / 2;
   localparam int SQRT_REM_WIDTH = ROOT_WIDTH + 2;
   localparam int QUOT_WIDTH     = UNIT_FRAC + 1;
   localparam int SPREAD_WIDTH   = LINE_WIDTH_BITS + SCALE_WIDTH + SPREAD_SHIFT;
   localparam int PROD_WIDTH     = SPREAD_WIDTH + QUOT_WIDTH;
   localparam int ROUND_SHIFT    = WIDTH_FRAC + SCALE_FRAC + UNIT_FRAC - FRAC_BITS;
   localparam int MAG_WIDTH      = PROD_WIDTH + 1 - ROUND_SHIFT;
   localparam int TAN_WIDTH      = MAG_WIDTH + 1;
   localparam int SUM_WIDTH      = ((SCALED_WIDTH > TAN_WIDTH) ? SCALED_WIDTH : TAN_WIDTH) + 1;
   localparam int CLAMP_WIDTH    = (SUM_WIDTH > OUT_WIDTH) ? SUM_WIDTH : OUT_WIDTH;

   // Normalization: a big step shifts the sum of squares by twice NORM_BIG bits.
   localparam int NORM_BIG = 8;

   localparam int SQRT_STEPS = ROOT_WIDTH;
   localparam int DIV_STEPS  = QUOT_WIDTH;
   localparam int STEP_COUNT_WIDTH =
      $clog2((SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS);

   localparam logic [PROD_WIDTH:0] ROUND_HALF = (PROD_WIDTH + 1)'(1) << (ROUND_SHIFT - 1);
   localparam logic [QUOT_WIDTH-1:0] UNIT_ONE = QUOT_WIDTH'(1) << UNIT_FRAC;

   localparam logic signed [CLAMP_WIDTH-1:0] OUT_MAX =
      CLAMP_WIDTH'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
   localparam logic signed [CLAMP_WIDTH-1:0] OUT_MIN =
      CLAMP_WIDTH'(-(64'sd1 <<< (OUT_WIDTH - 1)));

   // Strip order
   localparam int VERTEX_COUNT_WIDTH = $clog2(STRIP_VERTICES);
   localparam logic [VERTEX_COUNT_WIDTH-1:0] FIRST_VERTEX  = '0;
   localparam logic [VERTEX_COUNT_WIDTH-1:0] CENTER_FIRST  = VERTEX_COUNT_WIDTH'(2);
   localparam logic [VERTEX_COUNT_WIDTH-1:0] CENTER_SECOND = VERTEX_COUNT_WIDTH'(3);
   localparam logic [VERTEX_COUNT_WIDTH-1:0] LAST_VERTEX   = VERTEX_COUNT_WIDTH'(STRIP_VERTICES - 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = SCALE_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SCALE = 0,
      CSR_RED   = 1,
      CSR_GREEN = 2,
      CSR_BLUE  = 3,
      CSR_ALPHA = 4
   } csr_index_type;

   localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = SCALE_WIDTH'(256);
   localparam logic [COLOR_WIDTH-1:0] COLOR_RESET = COLOR_WIDTH'(255);

   typedef enum logic [3:0] {
      ENG_IDLE,
      ENG_SQUARE,
      ENG_SUM,
      ENG_NORM,
      ENG_SQRT,
      ENG_DIV,
      ENG_MUL,
      ENG_ROUND,
      ENG_DONE
   } engine_state_type;

   typedef struct packed {
      logic signed [SCALED_WIDTH-1:0] x1;
      logic signed [SCALED_WIDTH-1:0] y1;
      logic signed [SCALED_WIDTH-1:0] x2;
      logic signed [SCALED_WIDTH-1:0] y2;
      logic [SPREAD_WIDTH-1:0]        spread;
      logic [DIR_WIDTH-1:0]           ax;
      logic [DIR_WIDTH-1:0]           ay;
      logic                           dx_neg;
      logic                           dy_pos;
   } seg_type;

   typedef struct packed {
      logic signed [SCALED_WIDTH-1:0] x1;
      logic signed [SCALED_WIDTH-1:0] y1;
      logic signed [SCALED_WIDTH-1:0] x2;
      logic signed [SCALED_WIDTH-1:0] y2;
      logic signed [TAN_WIDTH-1:0]    tx;
      logic signed [TAN_WIDTH-1:0]    ty;
   } strip_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] x;
      logic signed [OUT_WIDTH-1:0] y;
      logic [COLOR_WIDTH-1:0]      red;
      logic [COLOR_WIDTH-1:0]      green;
      logic [COLOR_WIDTH-1:0]      blue;
      logic [COLOR_WIDTH-1:0]      opacity;
      logic                        last;
   } vertex_type;

endpackage

`default_nettype wire

// ===== rtl/lqs_channels.sv =====
`default_nettype none

interface lqs_req_if import lqs_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;
   logic [LINE_WIDTH_BITS-1:0]    line_width;

   modport source (output valid, start_x, start_y, end_x, end_y, line_width, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, line_width, output ready);
endinterface

interface lqs_rsp_if import lqs_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] vertex_x;
   logic signed [OUT_WIDTH-1:0] vertex_y;
   logic [COLOR_WIDTH-1:0]      vertex_red;
   logic [COLOR_WIDTH-1:0]      vertex_green;
   logic [COLOR_WIDTH-1:0]      vertex_blue;
   logic [COLOR_WIDTH-1:0]      vertex_opacity;
   logic                        last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_red, vertex_green, vertex_blue,
                   vertex_opacity, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_red, vertex_green, vertex_blue,
                 vertex_opacity, last_vertex, output ready);
endinterface

interface lqs_csr_if import lqs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lqs_front.sv =====
`default_nettype none

module lqs_front import lqs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   lqs_req_if.sink                     req_ch,
   input  wire logic [SCALE_WIDTH-1:0] scale_factor,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output seg_type                     push_seg
);

   logic signed [COORD_WIDTH+SCALE_WIDTH:0] prod_x1, prod_y1, prod_x2, prod_y2;
   logic [LINE_WIDTH_BITS+SCALE_WIDTH-1:0]  lw_prod;

   logic                           f1_vld_ff;
   logic signed [SCALED_WIDTH-1:0] f1_x1_ff, f1_y1_ff, f1_x2_ff, f1_y2_ff;
   logic [SPREAD_WIDTH-1:0]        f1_spread_ff;

   logic signed [DELTA_WIDTH-1:0] dx, dy;
   logic [DELTA_WIDTH-1:0]        adx, ady, mag_or;
   logic [PRE_SHIFT_WIDTH-1:0]    pre_sh;
   logic [EXT_WIDTH-1:0]          ax_ext, ay_ext;
   logic                          zero_len;

   logic    f2_vld_ff;
   logic    f2_zero_ff;
   seg_type f2_seg_ff;

   logic f1_free, f2_free, accept;

   assign prod_x1 = req_ch.start_x * $signed({1'b0, scale_factor});
   assign prod_y1 = req_ch.start_y * $signed({1'b0, scale_factor});
   assign prod_x2 = req_ch.end_x * $signed({1'b0, scale_factor});
   assign prod_y2 = req_ch.end_y * $signed({1'b0, scale_factor});
   assign lw_prod = req_ch.line_width * scale_factor;

   assign f2_free = !f2_vld_ff || f2_zero_ff || push_ready;
   assign f1_free = !f1_vld_ff || f2_free;
   assign req_ch.ready = f1_free;
   assign accept = req_ch.valid && f1_free;

   always_comb begin
      dx = DELTA_WIDTH'(f1_x2_ff) - DELTA_WIDTH'(f1_x1_ff);
      dy = DELTA_WIDTH'(f1_y2_ff) - DELTA_WIDTH'(f1_y1_ff);
      adx = dx[DELTA_WIDTH-1] ? DELTA_WIDTH'(-dx) : DELTA_WIDTH'(dx);
      ady = dy[DELTA_WIDTH-1] ? DELTA_WIDTH'(-dy) : DELTA_WIDTH'(dy);
      zero_len = (dx == '0) && (dy == '0);
      // Long deltas are brought down together until both fit the direction width.
      mag_or = adx | ady;
      pre_sh = '0;
      for (int j = DIR_WIDTH; j < DELTA_WIDTH; j++) begin
         if (mag_or[j]) begin
            pre_sh = PRE_SHIFT_WIDTH'(j - DIR_WIDTH + 1);
         end
      end
      ax_ext = EXT_WIDTH'(adx) >> pre_sh;
      ay_ext = EXT_WIDTH'(ady) >> pre_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         if (f1_free) begin
            f1_vld_ff <= accept;
         end
         if (f2_free) begin
            f2_vld_ff <= f1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_x1_ff     <= prod_x1[COORD_WIDTH+SCALE_WIDTH:SCALE_FRAC];
         f1_y1_ff     <= prod_y1[COORD_WIDTH+SCALE_WIDTH:SCALE_FRAC];
         f1_x2_ff     <= prod_x2[COORD_WIDTH+SCALE_WIDTH:SCALE_FRAC];
         f1_y2_ff     <= prod_y2[COORD_WIDTH+SCALE_WIDTH:SCALE_FRAC];
         f1_spread_ff <= {lw_prod, {SPREAD_SHIFT{1'b0}}};
      end
      if (f2_free && f1_vld_ff) begin
         f2_zero_ff       <= zero_len;
         f2_seg_ff.x1     <= f1_x1_ff;
         f2_seg_ff.y1     <= f1_y1_ff;
         f2_seg_ff.x2     <= f1_x2_ff;
         f2_seg_ff.y2     <= f1_y2_ff;
         f2_seg_ff.spread <= f1_spread_ff;
         f2_seg_ff.ax     <= ax_ext[DIR_WIDTH-1:0];
         f2_seg_ff.ay     <= ay_ext[DIR_WIDTH-1:0];
         f2_seg_ff.dx_neg <= dx[DELTA_WIDTH-1];
         f2_seg_ff.dy_pos <= !dy[DELTA_WIDTH-1] && (dy != '0);
      end
   end

   // A zero-length segment is dropped here and never reaches the queue.
   assign push_valid = f2_vld_ff && !f2_zero_ff;
   assign push_seg   = f2_seg_ff;

endmodule

`default_nettype wire

// ===== rtl/lqs_queue.sv =====
`default_nettype none

module lqs_queue import lqs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  seg_type   push_seg,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output seg_type   pop_seg
);

   seg_type                      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff;
   logic                         push, pop;

   assign push_ready = (count_ff != QUEUE_COUNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_seg    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_seg;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/lqs_engine.sv =====
`default_nettype none

module lqs_engine import lqs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic pop_valid,
   output logic      pop_ready,
   input  seg_type   pop_seg,
   output logic      strip_valid,
   input  wire logic strip_ready,
   output strip_type strip
);

   engine_state_type state_ff, state_in;

   seg_type                       seg_ff;
   logic [NORM_WIDTH-1:0]         ax_ff, ay_ff;
   logic [SQUARE_WIDTH-1:0]       sqx_ff, sqy_ff;
   logic [SUMSQ_WIDTH-1:0]        rad_ff;
   logic [SQRT_REM_WIDTH-1:0]     srem_ff;
   logic [ROOT_WIDTH-1:0]         root_ff;
   logic [STEP_COUNT_WIDTH-1:0]   cnt_ff;
   logic [ROOT_WIDTH-1:0]         remx_ff, remy_ff;
   logic [QUOT_WIDTH-1:0]         bitsx_ff, bitsy_ff;
   logic [QUOT_WIDTH-1:0]         qx_ff, qy_ff;
   logic [PROD_WIDTH-1:0]         px_ff, py_ff;
   strip_type                     strip_ff;

   logic                          norm_big, norm_done;
   logic [SQRT_REM_WIDTH+1:0]     sq_r2, sq_trial;
   logic [SQRT_REM_WIDTH-1:0]     srem_next;
   logic [ROOT_WIDTH-1:0]         root_next;
   logic [ROOT_WIDTH:0]           dvx_r2, dvy_r2;
   logic [ROOT_WIDTH-1:0]         remx_next, remy_next;
   logic                          qx_bit, qy_bit;
   logic [PROD_WIDTH:0]           rx_sum, ry_sum;
   logic signed [TAN_WIDTH-1:0]   tan_mx, tan_my;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign norm_big  = (rad_ff[SUMSQ_WIDTH-1 -: 2*NORM_BIG] == '0);
   assign norm_done = (rad_ff[SUMSQ_WIDTH-1 -: 2] != 2'b00);

   always_comb begin
      state_in    = state_ff;
      pop_ready   = 1'b0;
      strip_valid = 1'b0;
      unique case (state_ff)
         ENG_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               state_in = ENG_SQUARE;
            end
         end
         ENG_SQUARE: state_in = ENG_SUM;
         ENG_SUM:    state_in = ENG_NORM;
         ENG_NORM: begin
            if (norm_done) begin
               state_in = ENG_SQRT;
            end
         end
         ENG_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = ENG_DIV;
            end
         end
         ENG_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ENG_MUL;
            end
         end
         ENG_MUL:   state_in = ENG_ROUND;
         ENG_ROUND: state_in = ENG_DONE;
         ENG_DONE: begin
            strip_valid = 1'b1;
            if (strip_ready) begin
               state_in = ENG_IDLE;
            end
         end
         default: state_in = ENG_IDLE;
      endcase
   end

   // One root bit per cycle, two radicand bits brought down each step.
   always_comb begin
      sq_r2    = {srem_ff, rad_ff[SUMSQ_WIDTH-1 -: 2]};
      sq_trial = (SQRT_REM_WIDTH + 2)'({root_ff, 2'b01});
      if (sq_r2 >= sq_trial) begin
         srem_next = SQRT_REM_WIDTH'(sq_r2 - sq_trial);
         root_next = {root_ff[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         srem_next = SQRT_REM_WIDTH'(sq_r2);
         root_next = {root_ff[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   // Two restoring dividers share the root as divisor, one quotient bit a cycle.
   always_comb begin
      dvx_r2 = {remx_ff, bitsx_ff[QUOT_WIDTH-1]};
      dvy_r2 = {remy_ff, bitsy_ff[QUOT_WIDTH-1]};
      qx_bit = (dvx_r2 >= {1'b0, root_ff});
      qy_bit = (dvy_r2 >= {1'b0, root_ff});
      remx_next = qx_bit ? ROOT_WIDTH'(dvx_r2 - {1'b0, root_ff}) : ROOT_WIDTH'(dvx_r2);
      remy_next = qy_bit ? ROOT_WIDTH'(dvy_r2 - {1'b0, root_ff}) : ROOT_WIDTH'(dvy_r2);
   end

   always_comb begin
      rx_sum = {1'b0, px_ff} + ROUND_HALF;
      ry_sum = {1'b0, py_ff} + ROUND_HALF;
      tan_mx = $signed({1'b0, rx_sum[PROD_WIDTH:ROUND_SHIFT]});
      tan_my = $signed({1'b0, ry_sum[PROD_WIDTH:ROUND_SHIFT]});
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ENG_IDLE: begin
            if (pop_valid) begin
               seg_ff <= pop_seg;
               ax_ff  <= NORM_WIDTH'(pop_seg.ax);
               ay_ff  <= NORM_WIDTH'(pop_seg.ay);
            end
         end
         ENG_SQUARE: begin
            sqx_ff <= ax_ff[DIR_WIDTH-1:0] * ax_ff[DIR_WIDTH-1:0];
            sqy_ff <= ay_ff[DIR_WIDTH-1:0] * ay_ff[DIR_WIDTH-1:0];
         end
         ENG_SUM: begin
            rad_ff <= SUMSQ_WIDTH'(sqx_ff) + SUMSQ_WIDTH'(sqy_ff);
         end
         ENG_NORM: begin
            // The deltas move one bit for every two bits of the sum of squares.
            if (norm_big) begin
               rad_ff <= rad_ff << (2 * NORM_BIG);
               ax_ff  <= ax_ff << NORM_BIG;
               ay_ff  <= ay_ff << NORM_BIG;
            end else if (!norm_done) begin
               rad_ff <= rad_ff << 2;
               ax_ff  <= ax_ff << 1;
               ay_ff  <= ay_ff << 1;
            end else begin
               srem_ff <= '0;
               root_ff <= '0;
               cnt_ff  <= STEP_COUNT_WIDTH'(SQRT_STEPS - 1);
            end
         end
         ENG_SQRT: begin
            srem_ff <= srem_next;
            root_ff <= root_next;
            rad_ff  <= rad_ff << 2;
            if (cnt_ff == '0) begin
               remx_ff  <= ROOT_WIDTH'(ax_ff >> 1);
               remy_ff  <= ROOT_WIDTH'(ay_ff >> 1);
               bitsx_ff <= {ax_ff[0], {(QUOT_WIDTH - 1){1'b0}}};
               bitsy_ff <= {ay_ff[0], {(QUOT_WIDTH - 1){1'b0}}};
               cnt_ff   <= STEP_COUNT_WIDTH'(DIV_STEPS - 1);
            end else begin
               cnt_ff   <= cnt_ff - 1'b1;
            end
         end
         ENG_DIV: begin
            remx_ff  <= remx_next;
            remy_ff  <= remy_next;
            bitsx_ff <= bitsx_ff << 1;
            bitsy_ff <= bitsy_ff << 1;
            qx_ff    <= {qx_ff[QUOT_WIDTH-2:0], qx_bit};
            qy_ff    <= {qy_ff[QUOT_WIDTH-2:0], qy_bit};
            cnt_ff   <= cnt_ff - 1'b1;
         end
         ENG_MUL: begin
            px_ff <= seg_ff.spread * qx_ff;
            py_ff <= seg_ff.spread * qy_ff;
         end
         ENG_ROUND: begin
            strip_ff.x1 <= seg_ff.x1;
            strip_ff.y1 <= seg_ff.y1;
            strip_ff.x2 <= seg_ff.x2;
            strip_ff.y2 <= seg_ff.y2;
            strip_ff.tx <= seg_ff.dy_pos ? -tan_my : tan_my;
            strip_ff.ty <= seg_ff.dx_neg ? -tan_mx : tan_mx;
         end
         default: begin
         end
      endcase
   end

   assign strip = strip_ff;

   a_root_normalized: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_DIV |-> root_ff[ROOT_WIDTH-1])
      else $error("segment length not normalized before divide");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_MUL |-> (qx_ff <= UNIT_ONE) && (qy_ff <= UNIT_ONE))
      else $error("unit direction component above one");

   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      state_ff == ENG_SQRT && $past(state_ff) == ENG_NORM |-> $past(norm_done))
      else $error("square root started on an unnormalized radicand");

endmodule

`default_nettype wire

// ===== rtl/lqs_emitter.sv =====
`default_nettype none

module lqs_emitter import lqs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   strip_valid,
   output logic                        strip_ready,
   input  strip_type                   strip,
   input  wire logic [COLOR_WIDTH-1:0] color_red,
   input  wire logic [COLOR_WIDTH-1:0] color_green,
   input  wire logic [COLOR_WIDTH-1:0] color_blue,
   input  wire logic [COLOR_WIDTH-1:0] color_alpha,
   lqs_rsp_if.source                   rsp_ch
);

   strip_type                      seg_ff;
   logic                           seg_vld_ff;
   logic [VERTEX_COUNT_WIDTH-1:0]  idx_ff;
   logic                           out_vld_ff;
   vertex_type                     out_ff;

   logic                           load, seg_end;
   logic signed [SCALED_WIDTH-1:0] base_x, base_y;
   logic signed [TAN_WIDTH-1:0]    off_x, off_y;
   logic signed [SUM_WIDTH-1:0]    sum_x, sum_y;
   vertex_type                     vert;

   function automatic logic signed [OUT_WIDTH-1:0] clamp_coord(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [CLAMP_WIDTH-1:0] w;
      w = CLAMP_WIDTH'(v);
      if (w > OUT_MAX) begin
         w = OUT_MAX;
      end else if (w < OUT_MIN) begin
         w = OUT_MIN;
      end
      return w[OUT_WIDTH-1:0];
   endfunction

   assign load        = seg_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign seg_end     = load && (idx_ff == LAST_VERTEX);
   assign strip_ready = !seg_vld_ff || seg_end;

   always_comb begin
      // Odd vertices sit on the second endpoint, even ones on the first.
      base_x = idx_ff[0] ? seg_ff.x2 : seg_ff.x1;
      base_y = idx_ff[0] ? seg_ff.y2 : seg_ff.y1;
      if (idx_ff < CENTER_FIRST) begin
         off_x = seg_ff.tx;
         off_y = seg_ff.ty;
      end else if (idx_ff > CENTER_SECOND) begin
         off_x = -seg_ff.tx;
         off_y = -seg_ff.ty;
      end else begin
         off_x = '0;
         off_y = '0;
      end
      sum_x = SUM_WIDTH'(base_x) + SUM_WIDTH'(off_x);
      sum_y = SUM_WIDTH'(base_y) + SUM_WIDTH'(off_y);
      vert.x       = clamp_coord(sum_x);
      vert.y       = clamp_coord(sum_y);
      vert.red     = color_red;
      vert.green   = color_green;
      vert.blue    = color_blue;
      vert.opacity = (idx_ff == CENTER_FIRST || idx_ff == CENTER_SECOND) ? color_alpha : '0;
      vert.last    = (idx_ff == LAST_VERTEX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         idx_ff     <= FIRST_VERTEX;
      end else begin
         if (strip_valid && strip_ready) begin
            seg_vld_ff <= 1'b1;
         end else if (seg_end) begin
            seg_vld_ff <= 1'b0;
         end
         if (load) begin
            out_vld_ff <= 1'b1;
            idx_ff     <= seg_end ? FIRST_VERTEX : idx_ff + 1'b1;
         end else if (rsp_ch.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (strip_valid && strip_ready) begin
         seg_ff <= strip;
      end
      if (load) begin
         out_ff <= vert;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.vertex_x       = out_ff.x;
   assign rsp_ch.vertex_y       = out_ff.y;
   assign rsp_ch.vertex_red     = out_ff.red;
   assign rsp_ch.vertex_green   = out_ff.green;
   assign rsp_ch.vertex_blue    = out_ff.blue;
   assign rsp_ch.vertex_opacity = out_ff.opacity;
   assign rsp_ch.last_vertex    = out_ff.last;

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      seg_vld_ff |-> idx_ff <= LAST_VERTEX)
      else $error("vertex index past end of strip");

endmodule

`default_nettype wire

// ===== rtl/line_quad_strip_expander.sv =====
// Channel   Dir  Handshake          Carries
// req_ch    in   valid/ready        one segment: two endpoints and a line width
// rsp_ch    out  valid/ready        one strip vertex, six per segment, last flagged
// csr_ch    in   valid/ready (=1)   register index and write data
//
// The front scales a segment, registers its direction and drops it if its length is zero.
// The engine handles one segment at a time: a square root and then
// two dividers in parallel, each producing one bit a cycle.
// The six vertices go out one per cycle while the receiver is ready, as the engine works on the next segment.
// A two-entry queue separates front and engine; either side stalls on its own.
// Reset is synchronous and clears control state and loads the register defaults.
`default_nettype none

module line_quad_strip_expander import lqs_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   lqs_req_if.sink   req_ch,
   lqs_rsp_if.source rsp_ch,
   lqs_csr_if.sink   csr_ch
);

   logic [SCALE_WIDTH-1:0] scale_ff;
   logic [COLOR_WIDTH-1:0] red_ff, green_ff, blue_ff, alpha_ff;

   logic      push_valid, push_ready, pop_valid, pop_ready;
   seg_type   push_seg, pop_seg;
   logic      strip_valid, strip_ready;
   strip_type strip;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         red_ff   <= COLOR_RESET;
         green_ff <= COLOR_RESET;
         blue_ff  <= COLOR_RESET;
         alpha_ff <= COLOR_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_SCALE: scale_ff <= csr_ch.data;
            CSR_RED:   red_ff   <= csr_ch.data[COLOR_WIDTH-1:0];
            CSR_GREEN: green_ff <= csr_ch.data[COLOR_WIDTH-1:0];
            CSR_BLUE:  blue_ff  <= csr_ch.data[COLOR_WIDTH-1:0];
            CSR_ALPHA: alpha_ff <= csr_ch.data[COLOR_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   lqs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .scale_factor (scale_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_seg     (push_seg)
   );

   lqs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_seg   (push_seg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_seg    (pop_seg)
   );

   lqs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_seg     (pop_seg),
      .strip_valid (strip_valid),
      .strip_ready (strip_ready),
      .strip       (strip)
   );

   lqs_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .strip_valid (strip_valid),
      .strip_ready (strip_ready),
      .strip       (strip),
      .color_red   (red_ff),
      .color_green (green_ff),
      .color_blue  (blue_ff),
      .color_alpha (alpha_ff),
      .rsp_ch      (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== verif/lqs_strip_scoreboard.sv =====
`timescale 1ns / 100ps

class lqs_strip_scoreboard;
   typedef struct {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] opacity;
      logic last;
   } vertex_t;

   vertex_t pending_vertices[$];
   logic [9:0] scale;
   logic [7:0] red, green, blue, alpha;
   int mismatches;
   int vertices_seen;
   int segments_seen;
   int empty_segments;

   function new();
      scale = 256;
      red = 255;
      green = 255;
      blue = 255;
      alpha = 255;
      mismatches = 0;
      vertices_seen = 0;
      segments_seen = 0;
      empty_segments = 0;
   endfunction

   function void set_register(lqs_pkg::csr_index_type index, logic [9:0] value);
      case (index)
         lqs_pkg::CSR_SCALE: scale = value;
         lqs_pkg::CSR_RED:   red = value[7:0];
         lqs_pkg::CSR_GREEN: green = value[7:0];
         lqs_pkg::CSR_BLUE:  blue = value[7:0];
         lqs_pkg::CSR_ALPHA: alpha = value[7:0];
         default: ;
      endcase
   endfunction

   // Arithmetic shift of a signed value is a floor division by a power of two.
   function longint scaled(logic signed [23:0] p);
      longint prod;
      prod = longint'(p) * longint'({1'b0, scale});
      return prod >>> 8;
   endfunction

   function longint unsigned root64(longint unsigned v);
      longint unsigned r, bit_val;
      r = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= r + bit_val) begin
            v = v - (r + bit_val);
            r = (r >> 1) + bit_val;
         end else begin
            r = r >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return r;
   endfunction

   function logic signed [27:0] clamp(longint v);
      if (v > 134217727) return 28'sd134217727;
      if (v < -134217728) return -28'sd134217728;
      return v[27:0];
   endfunction

   function void note_segment(logic signed [23:0] sx, logic signed [23:0] sy,
                              logic signed [23:0] ex, logic signed [23:0] ey,
                              logic [11:0] lw);
      longint x1, y1, x2, y2, dx, dy, tx, ty;
      longint vx[6], vy[6];
      longint unsigned spread, adx, ady, sumsq, len, ux, uy, mx, my;
      int k;
      vertex_t v;
      segments_seen++;
      x1 = scaled(sx);
      y1 = scaled(sy);
      x2 = scaled(ex);
      y2 = scaled(ey);
      spread = 64'(lw) * 64'(scale) * 8;
      dx = x2 - x1;
      dy = y2 - y1;
      if (dx == 0 && dy == 0) begin
         empty_segments++;
         return;
      end
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      while (((adx | ady) >> 30) != 0) begin
         adx = adx >> 1;
         ady = ady >> 1;
      end
      sumsq = adx * adx + ady * ady;
      k = 0;
      while (sumsq < (64'd1 << 60)) begin
         sumsq = sumsq << 2;
         k++;
      end
      len = root64(sumsq);
      ux = ((adx << k) << 30) / len;
      uy = ((ady << k) << 30) / len;
      mx = (spread * ux + (64'd1 << 33)) >> 34;
      my = (spread * uy + (64'd1 << 33)) >> 34;
      tx = (dy > 0) ? -longint'(my) : longint'(my);
      ty = (dx < 0) ? -longint'(mx) : longint'(mx);
      vx[0] = x1 + tx; vy[0] = y1 + ty;
      vx[1] = x2 + tx; vy[1] = y2 + ty;
      vx[2] = x1;      vy[2] = y1;
      vx[3] = x2;      vy[3] = y2;
      vx[4] = x1 - tx; vy[4] = y1 - ty;
      vx[5] = x2 - tx; vy[5] = y2 - ty;
      for (int i = 0; i < 6; i++) begin
         v.x = clamp(vx[i]);
         v.y = clamp(vy[i]);
         v.red = red;
         v.green = green;
         v.blue = blue;
         v.opacity = (i == 2 || i == 3) ? alpha : 8'd0;
         v.last = (i == 5);
         pending_vertices.push_back(v);
      end
   endfunction

   function void report(string what, longint got, longint want);
      $display("mismatch: vertex %0d %s got %0d expected %0d", vertices_seen, what, got, want);
      mismatches++;
   endfunction

   function void check_vertex(vertex_t got);
      vertex_t want;
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
         $display("mismatch: vertex %0d arrived with none expected", vertices_seen);
         mismatches++;
         return;
      end
      want = pending_vertices.pop_front();
      if (got.x !== want.x) report("x", got.x, want.x);
      if (got.y !== want.y) report("y", got.y, want.y);
      if (got.red !== want.red) report("red", got.red, want.red);
      if (got.green !== want.green) report("green", got.green, want.green);
      if (got.blue !== want.blue) report("blue", got.blue, want.blue);
      if (got.opacity !== want.opacity) report("opacity", got.opacity, want.opacity);
      if (got.last !== want.last) report("last", got.last, want.last);
   endfunction
endclass

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import lqs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   lqs_req_if req_ch();
   lqs_rsp_if rsp_ch();
   lqs_csr_if csr_ch();

   lqs_strip_scoreboard strips = new();
   bit calm = 0;
   bit hold_off = 0;
   bit done = 0;
   int idle_cycles = 0;

   line_quad_strip_expander i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.start_x = 0;
      req_ch.start_y = 0;
      req_ch.end_x = 0;
      req_ch.end_y = 0;
      req_ch.line_width = 0;
      rsp_ch.ready = 0;
      csr_ch.valid = 0;
      csr_ch.index = CSR_SCALE;
      csr_ch.data = 0;
   end

   // Input and output sampling at the rising edge, after all driving was settled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            strips.note_segment(req_ch.start_x, req_ch.start_y, req_ch.end_x, req_ch.end_y,
                                req_ch.line_width);
         if (rsp_ch.valid && rsp_ch.ready)
            strips.check_vertex('{rsp_ch.vertex_x, rsp_ch.vertex_y, rsp_ch.vertex_red,
                                  rsp_ch.vertex_green, rsp_ch.vertex_blue,
                                  rsp_ch.vertex_opacity, rsp_ch.last_vertex});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
         $display("timeout after %0d quiet cycles", idle_cycles);
         $display("** line_quad_strip_expander: FAILED **");
         $finish;
      end
   end

   // The receiver stalls in bursts, or for a long counted stretch once hold_off is set.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            rsp_ch.ready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1;
            @(negedge clock);
         end
      end
   end

   task automatic write_register(csr_index_type index, logic [9:0] value);
      csr_ch.valid <= 1;
      csr_ch.index <= index;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      strips.set_register(index, value);
      @(negedge clock);
      csr_ch.valid <= 0;
   endtask

   task automatic send_segment(logic [23:0] sx, logic [23:0] sy, logic [23:0] ex,
                               logic [23:0] ey, logic [11:0] lw);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.start_x <= sx;
      req_ch.start_y <= sy;
      req_ch.end_x <= ex;
      req_ch.end_y <= ey;
      req_ch.line_width <= lw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (strips.pending_vertices.size() != 0) @(negedge clock);
      // A zero-length segment may still be in the front; give it time to be dropped.
      repeat (100) @(negedge clock);
   endtask

   function automatic logic [23:0] coordinate();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 4095)) - 24'd2048;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic random_segments(int count);
      logic [23:0] sx, sy;
      for (int i = 0; i < count; i++) begin
         sx = coordinate();
         sy = coordinate();
         case ($urandom_range(0, 9))
            0: send_segment(sx, sy, sx, sy, 12'($urandom));
            1: send_segment(sx, sy, 24'($urandom), sy, 12'($urandom));
            2: send_segment(sx, sy, sx, 24'($urandom), 12'($urandom));
            default: send_segment(sx, sy, coordinate(), coordinate(), 12'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: axis lines in each direction, extremes, zero length, widths.
      send_segment(24'd0, 24'd0, 24'd256, 24'd0, 12'd16);
      send_segment(24'd0, 24'd0, -24'd256, 24'd0, 12'd16);
      send_segment(24'd0, 24'd0, 24'd0, 24'd256, 12'hFFF);
      send_segment(24'd0, 24'd0, 24'd0, -24'd256, 12'd1);
      send_segment(24'd100, 24'd100, 24'd100, 24'd100, 12'd5);
      send_segment(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 12'hFFF);
      send_segment(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 12'd0);
      send_segment(24'd1, 24'd0, 24'd0, 24'd1, 12'hFFF);
      send_segment(24'd0, 24'd0, 24'd3, 24'd4, 12'h800);
      drain();
      write_register(CSR_SCALE, 10'd1023);
      write_register(CSR_RED, 8'd0);
      write_register(CSR_GREEN, 8'hA5);
      write_register(CSR_BLUE, 8'h5A);
      write_register(CSR_ALPHA, 8'd0);
      send_segment(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 12'hFFF);
      send_segment(24'h800000, 24'd0, 24'h7FFFFF, 24'd1, 12'hFFF);
      send_segment(24'd0, 24'd0, 24'd1, 24'd0, 12'd1);
      random_segments(40);
      drain();
      write_register(CSR_SCALE, 10'd0);
      write_register(CSR_ALPHA, 8'hFF);
      send_segment(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 12'hFFF);
      send_segment(24'd5, 24'd5, 24'd9, 24'd9, 12'd3);
      drain();
      write_register(CSR_SCALE, 10'd1);
      write_register(CSR_RED, 8'hFF);
      random_segments(30);

      // The receiver holds off long enough that the block fills and input stalls;
      // the sender keeps offering items until the receiver lets go.
      hold_off = 1;
      random_segments(12);
      drain();
      write_register(CSR_SCALE, 10'($urandom_range(1, 1023)));
      write_register(CSR_GREEN, 8'($urandom));
      write_register(CSR_BLUE, 8'($urandom));
      write_register(CSR_ALPHA, 8'($urandom));
      random_segments(60);
      calm = 1;
      random_segments(30);
      drain();

      done = 1;
      $display("covered %0d segments, %0d of zero length, %0d vertices checked",
               strips.segments_seen, strips.empty_segments, strips.vertices_seen);
      $display("register settings included scale 0, 1, 1023 and extreme colors");
      if (strips.mismatches == 0 && strips.pending_vertices.size() == 0)
         $display("** line_quad_strip_expander: PASSED **");
      else
         $display("** line_quad_strip_expander: FAILED **");
      $finish;
   end
endmodule
